// File: design/sbd_pkg.sv
package sbd_pkg;

  // Fixed field and register widths
  localparam int PIX_W  = 8;
  localparam int DIM_W  = 13;
  localparam int COL_W  = 12;
  localparam int FACI_W = 5;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 13;
  localparam int SRC_LIMIT = 4096;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_FACTOR     = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_PIXEL  = 2'd0;
  localparam logic [1:0] ST_TRUNC  = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             source_ended;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] avg_red;
    logic [PIX_W-1:0] avg_green;
    logic [PIX_W-1:0] avg_blue;
    logic             frame_last;
    logic [1:0]       status;
  } pix_out_t;

  typedef enum logic [1:0] {
    RES_PIX,
    RES_TRUNC,
    RES_REJECT
  } res_kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SIZE,
    S_ALIGN,
    S_CHECK,
    S_STEP,
    S_READ,
    S_ACC,
    S_AVG,
    S_PUT
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic      take;
    logic      size_start;
    logic      align_start;
    logic      size_load;
    logic      open;
    logic      step;
    logic      acc;
    logic      avg_start;
    logic      put;
    res_kind_e kind;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic frame_open;
    logic reject;
    logic ended;
    logic trunc;
    logic active;
    logic emit;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// File: design/sbd_divider.sv
// Three-lane restoring divider, one quotient bit per cycle, shared divisor.
module sbd_divider #(
  parameter int DVD_W = 16,
  parameter int DVS_W = 9
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [2:0][DVD_W-1:0]       dvd_i,
  input  logic [DVS_W-1:0]            dvs_i,
  output logic [2:0][DVD_W-1:0]       quo_o,
  output logic                        done_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DVS_W-1:0]      dvs_q;
  logic [2:0][DVS_W-1:0] rem_q, rem_nx;
  logic [2:0][DVD_W-1:0] quo_q, quo_nx;
  logic [2:0][DVS_W:0]   trial;
  logic [2:0]            ge;

  // One restoring step per lane
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      trial[l]  = {rem_q[l], quo_q[l][DVD_W-1]};
      ge[l]     = (trial[l] >= {1'b0, dvs_q});
      rem_nx[l] = ge[l] ? DVS_W'(trial[l] - {1'b0, dvs_q}) : trial[l][DVS_W-1:0];
      quo_nx[l] = {quo_q[l][DVD_W-2:0], ge[l]};
    end
  end

  // Step counter
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Remainder and quotient shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dvd_i;
      dvs_q <= dvs_i;
    end else if (busy_q) begin
      rem_q <= rem_nx;
      quo_q <= quo_nx;
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

endmodule

// File: design/sbd_ctrl.sv
// Sequencer: frame setup, line-store update, averaging, result hand-off.
module sbd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sbd_pkg::sts_t sts_i,
  output sbd_pkg::cmd_t cmd_o
);

  sbd_pkg::ctrl_state_e state_q, state_d;
  sbd_pkg::res_kind_e   kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbd_pkg::S_IDLE;
      kind_q  <= sbd_pkg::RES_PIX;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cmd_o   = '0;
    cmd_o.kind = kind_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      sbd_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.frame_open) begin
            state_d = sbd_pkg::S_STEP;
          end else begin
            cmd_o.size_start = 1'b1;
            state_d = sbd_pkg::S_SIZE;
          end
        end
      end
      sbd_pkg::S_SIZE: begin
        if (sts_i.div_done) begin
          cmd_o.align_start = 1'b1;
          state_d = sbd_pkg::S_ALIGN;
        end
      end
      sbd_pkg::S_ALIGN: begin
        if (sts_i.div_done) begin
          cmd_o.size_load = 1'b1;
          state_d = sbd_pkg::S_CHECK;
        end
      end
      sbd_pkg::S_CHECK: begin
        if (sts_i.reject) begin
          kind_d  = sbd_pkg::RES_REJECT;
          state_d = sbd_pkg::S_PUT;
        end else begin
          cmd_o.open = 1'b1;
          state_d = sbd_pkg::S_STEP;
        end
      end
      sbd_pkg::S_STEP: begin
        cmd_o.step = 1'b1;
        if (sts_i.ended) begin
          if (sts_i.trunc) begin
            kind_d  = sbd_pkg::RES_TRUNC;
            state_d = sbd_pkg::S_PUT;
          end else begin
            state_d = sbd_pkg::S_IDLE;
          end
        end else if (sts_i.active) begin
          state_d = sbd_pkg::S_READ;
        end else begin
          state_d = sbd_pkg::S_IDLE;
        end
      end
      sbd_pkg::S_READ: begin
        state_d = sbd_pkg::S_ACC;
      end
      sbd_pkg::S_ACC: begin
        cmd_o.acc = 1'b1;
        if (sts_i.emit) begin
          cmd_o.avg_start = 1'b1;
          state_d = sbd_pkg::S_AVG;
        end else begin
          state_d = sbd_pkg::S_IDLE;
        end
      end
      sbd_pkg::S_AVG: begin
        if (sts_i.div_done) begin
          kind_d  = sbd_pkg::RES_PIX;
          state_d = sbd_pkg::S_PUT;
        end
      end
      sbd_pkg::S_PUT: begin
        if (sts_i.out_free) begin
          cmd_o.put = 1'b1;
          state_d = sbd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sbd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: design/sbd_datapath.sv
// Config registers, frame counters, column-sum line store, divider, output register.
module sbd_datapath #(
  parameter int MAX_OUT_WIDTH = 256,
  parameter int ALIGN         = 16,
  parameter int MAX_FACTOR    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sbd_pkg::CFG_AW-1:0]    cfg_addr_i,
  input  logic [sbd_pkg::CFG_DW-1:0]    cfg_wdata_i,
  input  sbd_pkg::pix_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sbd_pkg::pix_out_t             out_data_o,
  input  sbd_pkg::cmd_t                 cmd_i,
  output sbd_pkg::sts_t                 sts_o
);

  localparam int DIM_W  = sbd_pkg::DIM_W;
  localparam int COL_W  = sbd_pkg::COL_W;
  localparam int FAC_W  = $clog2(MAX_FACTOR + 1);
  localparam int CW     = (FAC_W > sbd_pkg::FACI_W) ? FAC_W : sbd_pkg::FACI_W;
  localparam int SUM_W  = $clog2(MAX_FACTOR * MAX_FACTOR * 255 + 1);
  localparam int DVD_W  = (SUM_W > DIM_W) ? SUM_W : DIM_W;
  localparam int SQ_W   = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
  localparam int AL_W   = $clog2(ALIGN + 1);
  localparam int DVS_W  = (SQ_W > AL_W) ? SQ_W : AL_W;
  localparam int AW     = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int CAP    = MAX_OUT_WIDTH / ALIGN * ALIGN;

  // Configuration registers
  logic [DIM_W-1:0]          cfg_w_q, cfg_h_q;
  logic [sbd_pkg::FACI_W-1:0] cfg_fac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q   <= DIM_W'(640);
      cfg_h_q   <= DIM_W'(480);
      cfg_fac_q <= sbd_pkg::FACI_W'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        sbd_pkg::CFG_SRC_WIDTH:  cfg_w_q   <= cfg_wdata_i[DIM_W-1:0];
        sbd_pkg::CFG_SRC_HEIGHT: cfg_h_q   <= cfg_wdata_i[DIM_W-1:0];
        sbd_pkg::CFG_FACTOR:     cfg_fac_q <= cfg_wdata_i[sbd_pkg::FACI_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped frame geometry
  logic [DIM_W-1:0] clamp_w, clamp_h;
  logic [CW-1:0]    fac_ext;
  logic [FAC_W-1:0] clamp_fac;

  always_comb begin
    clamp_w = cfg_w_q;
    if (cfg_w_q == '0) clamp_w = DIM_W'(1);
    else if (cfg_w_q > DIM_W'(sbd_pkg::SRC_LIMIT)) clamp_w = DIM_W'(sbd_pkg::SRC_LIMIT);
    clamp_h = cfg_h_q;
    if (cfg_h_q == '0) clamp_h = DIM_W'(1);
    else if (cfg_h_q > DIM_W'(sbd_pkg::SRC_LIMIT)) clamp_h = DIM_W'(sbd_pkg::SRC_LIMIT);
    fac_ext = CW'(cfg_fac_q);
    if (fac_ext == '0) clamp_fac = FAC_W'(1);
    else if (fac_ext > CW'(MAX_FACTOR)) clamp_fac = FAC_W'(MAX_FACTOR);
    else clamp_fac = FAC_W'(fac_ext);
  end

  // Frame state
  logic             open_q, open_d;
  logic [DIM_W-1:0] lat_w_q, lat_w_d, lat_h_q, lat_h_d;
  logic [FAC_W-1:0] lat_fac_q, lat_fac_d;
  logic [DIM_W-1:0] out_w_q, out_w_d, out_h_q, out_h_d;
  logic [COL_W-1:0] src_col_q, src_col_d, src_row_q, src_row_d;
  logic [FAC_W-1:0] cib_q, cib_d, rig_q, rig_d;
  logic [DIM_W-1:0] out_col_q, out_col_d, out_row_q, out_row_d;

  // Per-item registers
  sbd_pkg::pix_in_t       item_q;
  logic [AW-1:0]          addr_q, addr_d;
  logic                   first_q, first_d, emit_q, emit_d, last_q, last_d;
  logic [DVS_W-1:0]       fac_sq_q;

  // Divider interface
  logic                   div_start, div_done;
  logic [2:0][DVD_W-1:0]  div_dvd, div_quo;
  logic [DVS_W-1:0]       div_dvs;

  // Line store
  localparam int PIX_W_L = sbd_pkg::PIX_W;
  logic [2:0][SUM_W-1:0]  mem [MAX_OUT_WIDTH];
  logic [2:0][SUM_W-1:0]  rdata_q, new_sum;
  logic [2:0][PIX_W_L-1:0] px;

  // Step decode
  logic             active, trunc;
  logic [FAC_W-1:0] fac_m1, cib_inc, rig_inc;
  logic [DIM_W-1:0] src_col_inc, src_row_inc;
  logic [DIM_W-1:0] qw, qh, ow;

  assign fac_m1      = lat_fac_q - 1'b1;
  assign active      = (out_row_q < out_h_q) && (out_col_q < out_w_q) &&
                       (out_col_q < DIM_W'(MAX_OUT_WIDTH));
  assign trunc       = item_q.source_ended && (out_row_q < out_h_q);
  assign cib_inc     = cib_q + 1'b1;
  assign rig_inc     = rig_q + 1'b1;
  assign src_col_inc = {1'b0, src_col_q} + 1'b1;
  assign src_row_inc = {1'b0, src_row_q} + 1'b1;
  assign qw          = div_quo[0][DIM_W-1:0];
  assign qh          = div_quo[1][DIM_W-1:0];
  assign ow          = DIM_W'(qw * ALIGN);

  // Frame counters and geometry
  always_comb begin
    open_d    = open_q;
    lat_w_d   = lat_w_q;
    lat_h_d   = lat_h_q;
    lat_fac_d = lat_fac_q;
    out_w_d   = out_w_q;
    out_h_d   = out_h_q;
    src_col_d = src_col_q;
    src_row_d = src_row_q;
    cib_d     = cib_q;
    rig_d     = rig_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    addr_d    = addr_q;
    first_d   = first_q;
    emit_d    = emit_q;
    last_d    = last_q;

    if (cmd_i.size_start) begin
      lat_w_d   = clamp_w;
      lat_h_d   = clamp_h;
      lat_fac_d = clamp_fac;
    end

    if (cmd_i.size_load) begin
      out_w_d = (ow > DIM_W'(CAP)) ? DIM_W'(CAP) : ow;
      out_h_d = DIM_W'(qh * ALIGN);
    end

    if (cmd_i.open) begin
      open_d    = 1'b1;
      src_col_d = '0;
      src_row_d = '0;
      cib_d     = '0;
      rig_d     = '0;
      out_col_d = '0;
      out_row_d = '0;
    end

    if (cmd_i.step) begin
      addr_d  = out_col_q[AW-1:0];
      first_d = (rig_q == '0) && (cib_q == '0);
      emit_d  = active && (rig_q == fac_m1) && (cib_q == fac_m1);
      last_d  = (out_row_q == out_h_q - 1'b1) && (out_col_q == out_w_q - 1'b1);
      if (item_q.source_ended) begin
        open_d    = 1'b0;
        src_col_d = '0;
        src_row_d = '0;
        cib_d     = '0;
        rig_d     = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else begin
        // advance within the row
        if (cib_inc >= lat_fac_q) begin
          cib_d     = '0;
          out_col_d = out_col_q + 1'b1;
        end else begin
          cib_d = cib_inc;
        end
        // end of a source row
        if (src_col_inc >= lat_w_q) begin
          src_col_d = '0;
          cib_d     = '0;
          out_col_d = '0;
          if (out_row_q < out_h_q) begin
            if (rig_inc >= lat_fac_q) begin
              rig_d     = '0;
              out_row_d = out_row_q + 1'b1;
            end else begin
              rig_d = rig_inc;
            end
          end
          if (src_row_inc >= lat_h_q) begin
            open_d    = 1'b0;
            src_row_d = '0;
            rig_d     = '0;
            out_row_d = '0;
          end else begin
            src_row_d = src_row_inc[COL_W-1:0];
          end
        end else begin
          src_col_d = src_col_inc[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q    <= 1'b0;
      lat_w_q   <= DIM_W'(1);
      lat_h_q   <= DIM_W'(1);
      lat_fac_q <= FAC_W'(1);
      out_w_q   <= '0;
      out_h_q   <= '0;
      src_col_q <= '0;
      src_row_q <= '0;
      cib_q     <= '0;
      rig_q     <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      open_q    <= open_d;
      lat_w_q   <= lat_w_d;
      lat_h_q   <= lat_h_d;
      lat_fac_q <= lat_fac_d;
      out_w_q   <= out_w_d;
      out_h_q   <= out_h_d;
      src_col_q <= src_col_d;
      src_row_q <= src_row_d;
      cib_q     <= cib_d;
      rig_q     <= rig_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // Item and per-step flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) item_q <= in_data_i;
    addr_q   <= addr_d;
    first_q  <= first_d;
    emit_q   <= emit_d;
    last_q   <= last_d;
    fac_sq_q <= DVS_W'(lat_fac_q * lat_fac_q);
  end

  // Column sum update
  assign px[0] = item_q.red;
  assign px[1] = item_q.green;
  assign px[2] = item_q.blue;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      new_sum[c] = first_q ? SUM_W'(px[c]) : rdata_q[c] + SUM_W'(px[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) mem[addr_q] <= new_sum;
    rdata_q <= mem[addr_q];
  end

  // Divider operand select: size, alignment, then box average
  assign div_start = cmd_i.size_start || cmd_i.align_start || cmd_i.avg_start;

  always_comb begin
    if (cmd_i.size_start) begin
      div_dvd[0] = DVD_W'(clamp_w);
      div_dvd[1] = DVD_W'(clamp_h);
      div_dvd[2] = '0;
      div_dvs    = DVS_W'(clamp_fac);
    end else if (cmd_i.align_start) begin
      div_dvd[0] = DVD_W'(qw);
      div_dvd[1] = DVD_W'(qh);
      div_dvd[2] = '0;
      div_dvs    = DVS_W'(ALIGN);
    end else begin
      for (int c = 0; c < 3; c++) div_dvd[c] = DVD_W'(new_sum[c]);
      div_dvs = fac_sq_q;
    end
  end

  sbd_divider #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (div_dvd),
    .dvs_i   (div_dvs),
    .quo_o   (div_quo),
    .done_o  (div_done)
  );

  // Output register
  logic              out_valid_q;
  sbd_pkg::pix_out_t out_data_q, res;

  always_comb begin
    res = '0;
    unique case (cmd_i.kind)
      sbd_pkg::RES_PIX: begin
        res.avg_red    = div_quo[0][sbd_pkg::PIX_W-1:0];
        res.avg_green  = div_quo[1][sbd_pkg::PIX_W-1:0];
        res.avg_blue   = div_quo[2][sbd_pkg::PIX_W-1:0];
        res.frame_last = last_q;
        res.status     = sbd_pkg::ST_PIXEL;
      end
      sbd_pkg::RES_TRUNC:  res.status = sbd_pkg::ST_TRUNC;
      sbd_pkg::RES_REJECT: res.status = sbd_pkg::ST_REJECT;
      default:             res.status = sbd_pkg::ST_REJECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.put) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.put) out_data_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Status back to the sequencer
  assign sts_o.frame_open = open_q;
  assign sts_o.reject     = (out_w_q < DIM_W'(ALIGN)) || (out_h_q < DIM_W'(ALIGN));
  assign sts_o.ended      = item_q.source_ended;
  assign sts_o.trunc      = trunc;
  assign sts_o.active     = active;
  assign sts_o.emit       = emit_q;
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  a_put_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.put |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an unread word");

  a_open_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (out_w_q >= DIM_W'(ALIGN) && out_h_q >= DIM_W'(ALIGN)))
    else $error("frame open with rejected output size");

  a_block_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (cib_q < lat_fac_q && rig_q < lat_fac_q))
    else $error("block counters beyond factor");

endmodule

// File: design/streaming_box_downscale.sv
// Channel  Handshake                    Word
// in       in_valid_i / in_ready_o      in_data_i   (sbd_pkg::pix_in_t)
// out      out_valid_o / out_ready_i    out_data_o  (sbd_pkg::pix_out_t)
// cfg      cfg_we_i (no wait)           cfg_addr_i, cfg_wdata_i
//
// One word is in flight at a time; the sequencer walks it through its steps.
// Pixel inside the crop: accept, step, store read, store write.
// Pixel closing a box: those steps, then the average division (16-bit divider, one bit a cycle) and the put.
// First word of a frame adds the size division, the alignment division and the size check.
// A result waiting on out_ready_i does not block the next word; a second
// result holds the sequencer until the output register frees.
// Reset clears control state; the line store needs no clearing.
module streaming_box_downscale #(
  parameter int MAX_OUT_WIDTH = 256,
  parameter int ALIGN         = 16,
  parameter int MAX_FACTOR    = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sbd_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [sbd_pkg::CFG_DW-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  sbd_pkg::pix_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output sbd_pkg::pix_out_t          out_data_o
);

  sbd_pkg::cmd_t cmd;
  sbd_pkg::sts_t sts;

  sbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sbd_datapath #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .ALIGN         (ALIGN),
    .MAX_FACTOR    (MAX_FACTOR)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
